>>> hw/rtl/sorted_keyed_record_table_top_assert.svh
// Assertion macros for the sorted record table.
// Used by the top level only; no other dependencies.
`ifndef SORTED_KEYED_RECORD_TABLE_TOP_ASSERT_SVH
`define SORTED_KEYED_RECORD_TABLE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SKRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SKRT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/skrt_pkg.sv
// Package for the sorted record table: payload types, codes and sizes.
// No dependencies.
`default_nettype none
package skrt_pkg;
    localparam int Capacity  = 64;
    localparam int NameBytes = 25;
    localparam int IdxW      = $clog2(Capacity);
    localparam int CntW      = $clog2(Capacity + 1);

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_SEARCH = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_ERASE  = 3'd3;
    localparam logic [2:0] ACT_LIST   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_EXISTS  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic        [2:0]  action;
        logic signed [31:0] part_key;
        logic signed [31:0] amount;
        logic        [63:0] name_bytes_0_7;
        logic        [63:0] name_bytes_8_15;
        logic        [63:0] name_bytes_16_23;
        logic        [7:0]  name_byte_24;
    } t_req;

    typedef struct packed {
        logic        [2:0]  status;
        logic signed [31:0] found_key;
        logic signed [31:0] quantity;
        logic        [63:0] out_name_0_7;
        logic        [63:0] out_name_8_15;
        logic        [63:0] out_name_16_23;
        logic        [7:0]  out_name_24;
        logic               last_result;
    } t_rsp;

    // One stored record: key, quantity and the 25 name bytes.
    typedef struct packed {
        logic signed [31:0]  key;
        logic signed [31:0]  qty;
        logic        [199:0] name;
    } t_rec;

    function automatic logic [199:0] name_mask();
        logic [199:0] m;
        m = '0;
        for (int b = 0; b < 25; b++) begin
            if (b < NameBytes) m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/skrt_ram.sv
// Record memory of the sorted table: one write port, one registered read port.
// Depends on skrt_pkg.
`default_nettype none
module skrt_ram (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [skrt_pkg::IdxW-1:0] i_waddr,
    input  wire skrt_pkg::t_rec       i_wdata,
    input  wire logic [skrt_pkg::IdxW-1:0] i_raddr,
    output skrt_pkg::t_rec            o_rdata
);
    import skrt_pkg::*;
    t_rec r_mem [Capacity];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/sorted_keyed_record_table_top.sv
// Top level of the sorted record table: command sequencer around one memory.
// Depends on skrt_pkg, skrt_ram and the assertion header.
`default_nettype none
`include "sorted_keyed_record_table_top_assert.svh"
// Usage: pulse start with a command word on i_req while busy is low.
// Each result word appears on o_rsp for one cycle with o_valid high; the
// receiver cannot stall, and the final word of a command has last_result set.
// Steps of a command, with n the number of stored records:
//   search/update: scan, decide, read-modify-write,
//   insert: scan to the insert point, one shift per record above it,
//   erase: scan, decide, report, one shift per record above it,
//   list: n words, one per cycle, each registered onto o_rsp.
// The result word of a single-word command is registered from the state that
// makes it; for an erase that shifts, the word comes out while busy is still
// high, and otherwise a new command can be taken as it comes out. Empty list,
// full insert and action codes 5 to 7 are handled in the idle state without
// raising busy; codes 5 to 7 produce no word and leave the table unchanged.
// A shift reads one entry and writes it one place over once the registered
// read data arrives. Reset empties the table at once; no clearing pass is
// needed, since only entries below the record count are ever used.
module sorted_keyed_record_table_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire skrt_pkg::t_req i_req,
    output logic                busy,
    output logic                o_valid,
    output skrt_pkg::t_rsp      o_rsp
);
    import skrt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_SHUP  = 7'b0001000,
        S_SHDN  = 7'b0010000,
        S_LIST  = 7'b0100000,
        S_WRITE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_ptr, n_ptr;      // address issued this cycle
    logic [CntW-1:0] r_rptr, n_rptr;    // address whose data arrives now
    logic            r_rv, n_rv;        // read data valid
    logic            r_hit, n_hit;
    logic [CntW-1:0] r_pos, n_pos;

    logic            we;
    logic [IdxW-1:0] waddr, raddr;
    t_rec            wdata, rdata;

    skrt_ram u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    t_rsp n_rsp;
    logic n_valid;
    logic signed [32:0] sum;
    t_rec newrec;

    always_comb begin
        newrec.key  = r_req.part_key;
        newrec.qty  = r_req.amount;
        newrec.name = {r_req.name_byte_24, r_req.name_bytes_16_23,
                       r_req.name_bytes_8_15, r_req.name_bytes_0_7} & name_mask();
        sum = 33'(rdata.qty) + 33'(r_req.amount);
    end

    function automatic t_rsp rec_rsp(t_rec r, logic last);
        t_rsp o;
        o.status = ST_OK;
        o.found_key = r.key;
        o.quantity = r.qty;
        o.out_name_0_7 = r.name[63:0];
        o.out_name_8_15 = r.name[127:64];
        o.out_name_16_23 = r.name[191:128];
        o.out_name_24 = r.name[199:192];
        o.last_result = last;
        return o;
    endfunction

    function automatic t_rsp blank(logic [2:0] st, logic signed [31:0] k);
        t_rsp o;
        o = '0;
        o.status = st;
        o.found_key = k;
        o.last_result = 1'b1;
        return o;
    endfunction

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_rptr  = r_ptr;
        n_rv    = 1'b0;
        n_hit   = r_hit;
        n_pos   = r_pos;
        n_valid = 1'b0;
        n_rsp   = '0;
        we      = 1'b0;
        waddr   = r_rptr[IdxW-1:0];
        wdata   = rdata;
        raddr   = r_ptr[IdxW-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_ptr = '0;
                n_rptr = '0;
                raddr = '0;
                if (start) begin
                    n_rv = r_count != '0;
                    n_ptr = CntW'(1);
                    priority if (i_req.action > ACT_LIST) begin
                        n_state = S_IDLE;
                    end else if (i_req.action == ACT_LIST) begin
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                            n_rsp = blank(ST_EMPTY, '0);
                        end else n_state = S_LIST;
                    end else if (i_req.action == ACT_INSERT &&
                                 r_count == CntW'(Capacity)) begin
                        n_valid = 1'b1;
                        n_rsp = blank(ST_FULL, i_req.part_key);
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Data for r_rptr arrives; stop at the first key not below.
                n_rv = r_ptr < r_count;
                n_ptr = r_ptr + 1'b1;
                if (!r_rv || rdata.key >= r_req.part_key) begin
                    n_pos = r_rv ? r_rptr : r_count;
                    n_hit = r_rv && rdata.key == r_req.part_key;
                    n_rv = 1'b0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                waddr = r_pos[IdxW-1:0];
                if (r_req.action == ACT_INSERT) begin
                    if (r_hit) begin
                        n_valid = 1'b1;
                        n_rsp = blank(ST_EXISTS, r_req.part_key);
                        n_state = S_IDLE;
                    end else begin
                        // Move entries up from the top down to r_pos.
                        raddr = IdxW'(r_count - 1'b1);
                        n_ptr = r_count - 1'b1;
                        n_rptr = n_ptr;
                        n_rv = r_count != r_pos;
                        n_state = n_rv ? S_SHUP : S_WRITE;
                    end
                end else if (!r_hit) begin
                    n_valid = 1'b1;
                    n_rsp = blank(ST_MISSING, r_req.part_key);
                    n_state = S_IDLE;
                end else begin
                    // Re-read the hit entry (last read was one past it).
                    raddr = r_pos[IdxW-1:0];
                    n_ptr = r_pos;
                    n_rptr = r_pos;
                    n_state = S_WRITE;
                end
            end
            S_SHUP: begin
                we = 1'b1;
                waddr = IdxW'(r_rptr + 1'b1);
                raddr = IdxW'(r_rptr - 1'b1);
                n_rptr = r_rptr - 1'b1;
                if (r_rptr == r_pos) n_state = S_WRITE;
            end
            S_WRITE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                waddr = r_pos[IdxW-1:0];
                unique case (r_req.action)
                    ACT_INSERT: begin
                        we = 1'b1;
                        wdata = newrec;
                        n_count = r_count + 1'b1;
                        n_rsp = rec_rsp(newrec, 1'b1);
                    end
                    ACT_UPDATE: begin
                        we = 1'b1;
                        wdata = rdata;
                        if (sum > 33'sh07FFFFFFF) wdata.qty = 32'sh7FFFFFFF;
                        else if (sum < -33'sh080000000) wdata.qty = 32'sh80000000;
                        else wdata.qty = sum[31:0];
                        n_rsp = rec_rsp(wdata, 1'b1);
                    end
                    ACT_ERASE: begin
                        n_rsp = rec_rsp(rdata, 1'b1);
                        raddr = IdxW'(r_pos + 1'b1);
                        n_rptr = r_pos + 1'b1;
                        if (r_pos + 1'b1 < r_count) n_state = S_SHDN;
                        else n_count = r_count - 1'b1;
                    end
                    default: n_rsp = rec_rsp(rdata, 1'b1);
                endcase
            end
            S_SHDN: begin
                we = 1'b1;
                waddr = IdxW'(r_rptr - 1'b1);
                raddr = IdxW'(r_rptr + 1'b1);
                n_rptr = r_rptr + 1'b1;
                if (r_rptr + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                n_valid = 1'b1;
                n_rsp = rec_rsp(rdata, r_rptr + 1'b1 == r_count);
                n_ptr = r_ptr + 1'b1;
                if (r_rptr + 1'b1 == r_count) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            o_valid <= n_valid;
            r_rv    <= n_rv;
        end
        r_ptr  <= n_ptr;
        r_rptr <= n_rptr;
        r_hit  <= n_hit;
        r_pos  <= n_pos;
        o_rsp  <= n_rsp;
        if (r_state == S_IDLE && start) r_req <= i_req;
    end

    assign busy = r_state != S_IDLE;

    `SKRT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CntW'(Capacity))
    `SKRT_ASSERT_NXT(a_idle_quiet, r_state == S_IDLE && !start, !o_valid)
    `SKRT_ASSERT_IMP(a_no_write_idle, r_state == S_IDLE, !we)
endmodule
`default_nettype wire
